[design/pmsfd_pkg.sv]
`timescale 1ns / 1ps

package pmsfd_pkg;

  localparam int FRAME_BYTES   = 32;
  localparam int NUM_CHANNELS  = 12;
  localparam int INDEX_W       = 5;
  localparam int CHANNEL_W     = 4;
  localparam int WORD_W        = 16;
  localparam int BYTE_W        = 8;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h42;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h4D;

  localparam logic [INDEX_W-1:0] IDX_FIRST_BODY = INDEX_W'(2);
  localparam logic [INDEX_W-1:0] IDX_LENGTH_LO  = INDEX_W'(3);
  localparam logic [INDEX_W-1:0] IDX_MEAS_FIRST = INDEX_W'(4);
  localparam logic [INDEX_W-1:0] IDX_MEAS_LAST  = INDEX_W'(27);
  localparam logic [INDEX_W-1:0] IDX_VERSION    = INDEX_W'(28);
  localparam logic [INDEX_W-1:0] IDX_ERROR      = INDEX_W'(29);
  localparam logic [INDEX_W-1:0] IDX_SUM_END    = INDEX_W'(30);
  localparam logic [INDEX_W-1:0] IDX_LAST       = INDEX_W'(FRAME_BYTES - 1);

  localparam logic [CHANNEL_W-1:0] MEAS_BASE    = CHANNEL_W'(2);
  localparam logic [CHANNEL_W-1:0] LAST_CHANNEL = CHANNEL_W'(NUM_CHANNELS - 1);

  localparam logic [WORD_W-1:0] HEADER_SUM =
    WORD_W'({8'h00, HDR_FIRST} + {8'h00, HDR_SECOND});

  typedef enum logic [1:0] {
    PH_HUNT      = 2'd0,
    PH_GOT_FIRST = 2'd1,
    PH_COLLECT   = 2'd2
  } phase_t;

  typedef logic [NUM_CHANNELS-1:0][WORD_W-1:0] channel_bank_t;

  typedef struct packed {
    logic          load;
    channel_bank_t values;
    logic [WORD_W-1:0] length;
    logic [BYTE_W-1:0] version;
    logic [BYTE_W-1:0] error;
    logic          checksum_ok;
  } frame_t;

endpackage

[design/pmsfd_parser.sv]
`timescale 1ns / 1ps

module pmsfd_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_enable,
  input  logic                         cfg_write_data,
  input  logic                         accept,
  input  logic [pmsfd_pkg::BYTE_W-1:0] rx_byte,
  output logic                         at_frame_end,
  output pmsfd_pkg::frame_t            frame
);

  logic                           average_enable;
  pmsfd_pkg::phase_t              phase;
  pmsfd_pkg::phase_t              phase_next;
  logic [pmsfd_pkg::INDEX_W-1:0]  byte_index;
  logic [pmsfd_pkg::INDEX_W-1:0]  byte_index_next;
  logic [pmsfd_pkg::BYTE_W-1:0]   high_byte;
  logic [pmsfd_pkg::BYTE_W-1:0]   high_byte_next;
  logic [pmsfd_pkg::WORD_W-1:0]   running_sum;
  logic [pmsfd_pkg::WORD_W-1:0]   running_sum_next;
  logic [pmsfd_pkg::WORD_W-1:0]   length_word;
  logic [pmsfd_pkg::WORD_W-1:0]   length_word_next;
  logic [pmsfd_pkg::BYTE_W-1:0]   version_byte;
  logic [pmsfd_pkg::BYTE_W-1:0]   version_byte_next;
  logic [pmsfd_pkg::BYTE_W-1:0]   error_byte;
  logic [pmsfd_pkg::BYTE_W-1:0]   error_byte_next;
  pmsfd_pkg::channel_bank_t       channel_store;

  logic                           collecting;
  logic                           store_write;
  logic [pmsfd_pkg::CHANNEL_W-1:0] store_channel;
  logic [pmsfd_pkg::WORD_W-1:0]   new_word;
  logic [pmsfd_pkg::WORD_W:0]     pair_sum;
  logic [pmsfd_pkg::WORD_W-1:0]   store_value;

  assign collecting   = (phase == pmsfd_pkg::PH_COLLECT);
  assign at_frame_end = collecting && (byte_index == pmsfd_pkg::IDX_LAST);
  assign new_word     = {high_byte, rx_byte};
  assign store_channel = byte_index[pmsfd_pkg::INDEX_W-1:1] - pmsfd_pkg::MEAS_BASE;
  assign pair_sum     = {1'b0, channel_store[store_channel]} + {1'b0, new_word};
  assign store_value  = average_enable ? pair_sum[pmsfd_pkg::WORD_W:1] : new_word;

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    case (phase)
      pmsfd_pkg::PH_GOT_FIRST: begin
        if (rx_byte == pmsfd_pkg::HDR_SECOND) begin
          phase_next      = pmsfd_pkg::PH_COLLECT;
          byte_index_next = pmsfd_pkg::IDX_FIRST_BODY;
        end else if (rx_byte != pmsfd_pkg::HDR_FIRST) begin
          phase_next = pmsfd_pkg::PH_HUNT;
        end
      end
      pmsfd_pkg::PH_COLLECT: begin
        if (byte_index == pmsfd_pkg::IDX_LAST) begin
          phase_next      = pmsfd_pkg::PH_HUNT;
          byte_index_next = '0;
        end else begin
          byte_index_next = byte_index + 1'b1;
        end
      end
      default: begin
        phase_next = (rx_byte == pmsfd_pkg::HDR_FIRST) ? pmsfd_pkg::PH_GOT_FIRST
                                                       : pmsfd_pkg::PH_HUNT;
      end
    endcase
  end

  always_comb begin
    high_byte_next    = high_byte;
    running_sum_next  = running_sum;
    length_word_next  = length_word;
    version_byte_next = version_byte;
    error_byte_next   = error_byte;
    store_write       = 1'b0;
    if ((phase == pmsfd_pkg::PH_GOT_FIRST) && (rx_byte == pmsfd_pkg::HDR_SECOND)) begin
      running_sum_next = pmsfd_pkg::HEADER_SUM;
    end
    if (collecting) begin
      if (byte_index < pmsfd_pkg::IDX_SUM_END) begin
        running_sum_next = running_sum + {8'h00, rx_byte};
      end
      if (byte_index == pmsfd_pkg::IDX_LENGTH_LO) begin
        length_word_next = new_word;
      end else if ((byte_index >= pmsfd_pkg::IDX_MEAS_FIRST) &&
                   (byte_index <= pmsfd_pkg::IDX_MEAS_LAST)) begin
        if (byte_index[0]) begin
          store_write = 1'b1;
        end else begin
          high_byte_next = rx_byte;
        end
      end else if (byte_index == pmsfd_pkg::IDX_VERSION) begin
        version_byte_next = rx_byte;
      end else if (byte_index == pmsfd_pkg::IDX_ERROR) begin
        error_byte_next = rx_byte;
      end else if (byte_index != pmsfd_pkg::IDX_LAST) begin
        high_byte_next = rx_byte;
      end
    end
  end

  always_comb begin
    frame.load        = accept && at_frame_end;
    frame.values      = channel_store;
    frame.length      = length_word;
    frame.version     = version_byte;
    frame.error       = error_byte;
    frame.checksum_ok = (running_sum == new_word);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_enable <= 1'b0;
    end else if (cfg_write_enable) begin
      average_enable <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= pmsfd_pkg::PH_HUNT;
      byte_index    <= '0;
      high_byte     <= '0;
      running_sum   <= '0;
      length_word   <= '0;
      version_byte  <= '0;
      error_byte    <= '0;
      channel_store <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      high_byte    <= high_byte_next;
      running_sum  <= running_sum_next;
      length_word  <= length_word_next;
      version_byte <= version_byte_next;
      error_byte   <= error_byte_next;
      if (store_write) begin
        channel_store[store_channel] <= store_value;
      end
    end
  end

endmodule

[design/pmsfd_emitter.sv]
`timescale 1ns / 1ps

module pmsfd_emitter (
  input  logic                            clk,
  input  logic                            rst,
  input  pmsfd_pkg::frame_t               frame,
  input  logic                            out_stall,
  output logic                            busy,
  output logic [pmsfd_pkg::CHANNEL_W-1:0] channel,
  output logic [pmsfd_pkg::WORD_W-1:0]    value,
  output logic [pmsfd_pkg::WORD_W-1:0]    frame_length,
  output logic [pmsfd_pkg::BYTE_W-1:0]    version,
  output logic [pmsfd_pkg::BYTE_W-1:0]    sensor_error,
  output logic                            checksum_ok,
  output logic                            last
);

  pmsfd_pkg::channel_bank_t            snapshot;
  logic [pmsfd_pkg::CHANNEL_W-1:0]     count;

  assign channel = count;
  assign value   = snapshot[count];
  assign last    = (count == pmsfd_pkg::LAST_CHANNEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (frame.load) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy && !out_stall) begin
      if (last) begin
        busy  <= 1'b0;
        count <= '0;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.load) begin
      snapshot     <= frame.values;
      frame_length <= frame.length;
      version      <= frame.version;
      sensor_error <= frame.error;
      checksum_ok  <= frame.checksum_ok;
    end
  end

endmodule

[design/particle_sensor_frame_decoder_core.sv]
`timescale 1ns / 1ps

// Decodes the 32-byte frames of a particle sensor from a stream of received bytes, one
// byte per cycle. After the final byte of a frame the twelve channel values, taken as a
// snapshot together with the length, version, error byte and checksum result, leave one
// transaction per cycle on the output channel unless stalled, channel 0 first, with last
// marking channel 11. Bytes keep flowing while these results drain; the input stalls only
// when the final byte of the next frame arrives before all twelve results of the previous
// frame have been taken, as the emitter's single snapshot bank holds one frame at a time.

module particle_sensor_frame_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_enable,
  input  logic                            cfg_write_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pmsfd_pkg::BYTE_W-1:0]    rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pmsfd_pkg::CHANNEL_W-1:0] channel,
  output logic [pmsfd_pkg::WORD_W-1:0]    value,
  output logic [pmsfd_pkg::WORD_W-1:0]    frame_length,
  output logic [pmsfd_pkg::BYTE_W-1:0]    version,
  output logic [pmsfd_pkg::BYTE_W-1:0]    sensor_error,
  output logic                            checksum_ok,
  output logic                            last
);

  logic              at_frame_end;
  logic              busy;
  logic              accept;
  pmsfd_pkg::frame_t frame;

  assign in_stall  = busy && at_frame_end;
  assign accept    = in_valid && !in_stall;
  assign out_valid = busy;

  pmsfd_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .accept           (accept),
    .rx_byte          (rx_byte),
    .at_frame_end     (at_frame_end),
    .frame            (frame)
  );

  pmsfd_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .out_stall    (out_stall),
    .busy         (busy),
    .channel      (channel),
    .value        (value),
    .frame_length (frame_length),
    .version      (version),
    .sensor_error (sensor_error),
    .checksum_ok  (checksum_ok),
    .last         (last)
  );

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    !(frame.load && busy))
    else $error("Frame loaded while results were still pending.");

  a_channel_steps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> (out_valid && channel == $past(channel) + 1'b1))
    else $error("Result channel did not advance by one.");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("Results continued past the last channel.");

  a_load_starts_run: assert property (@(posedge clk) disable iff (rst)
    frame.load |=> (out_valid && channel == '0))
    else $error("A completed frame did not start a result run at channel zero.");

endmodule
